### rtl/dtlq_pkg.sv
// Shared types and constants for the drop-tail link queue.
package dtlq_pkg;

    localparam int SIZE_W     = 16;
    localparam int CAP_W      = 11;
    localparam int SPEED_W    = 7;
    localparam int CFG_W      = 11;
    localparam int CFG_IDX_W  = 1;
    localparam int COUNT_W    = 32;
    localparam int WAIT_W     = 48;
    localparam int FILL_W     = 11;
    localparam int DIVIDEND_W = SIZE_W + 3;
    localparam int LIMIT_W    = 20;

    localparam logic [CAP_W-1:0]     CAP_RESET   = 11'd100;
    localparam logic [SPEED_W-1:0]   SPEED_RESET = 7'd11;
    localparam logic [WAIT_W-1:0]    WAIT_MAX    = 48'hFFFF_FFFF_FFFF;
    localparam logic [COUNT_W-1:0]   COUNT_MAX   = 32'hFFFF_FFFF;

    localparam logic [CFG_IDX_W-1:0] REG_CAPACITY = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_SPEED    = 1'b1;

    typedef struct packed {
        logic              arrival_valid;
        logic [SIZE_W-1:0] packet_size;
    } item_t;

    typedef struct packed {
        logic               dropped_now;
        logic               delivered_now;
        logic [COUNT_W-1:0] arrived_total;
        logic [COUNT_W-1:0] delivered_total;
        logic [COUNT_W-1:0] dropped_total;
        logic [WAIT_W-1:0]  wait_sum;
        logic [FILL_W-1:0]  queue_fill;
        logic               link_busy;
    } result_t;

endpackage

### rtl/dtlq_div.sv
// Restoring serial divider, one quotient bit per cycle, for the send length.
module dtlq_div
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic [dtlq_pkg::DIVIDEND_W-1:0]   dividend,
    input  logic [dtlq_pkg::SPEED_W-1:0]      divisor,
    output logic                              done,
    output logic [dtlq_pkg::DIVIDEND_W-1:0]   quotient
);

    localparam int DW     = dtlq_pkg::DIVIDEND_W;
    localparam int VW     = dtlq_pkg::SPEED_W;
    localparam int STEP_W = $clog2(DW);

    logic              run_reg;
    logic              run_next;
    logic              done_reg;
    logic              done_next;
    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;
    logic [DW-1:0]     quo_reg;
    logic [DW-1:0]     quo_next;
    logic [VW-1:0]     rem_reg;
    logic [VW-1:0]     rem_next;
    logic [VW-1:0]     div_reg;
    logic [VW-1:0]     div_next;

    logic [VW:0]       shifted;
    logic [VW:0]       diff;
    logic              fits;

    assign shifted = {rem_reg, quo_reg[DW-1]};
    assign fits    = shifted >= {1'b0, div_reg};
    assign diff    = shifted - {1'b0, div_reg};

    always_comb
    begin
        run_next  = run_reg;
        done_next = 1'b0;
        step_next = step_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;
        if (start)
        begin
            run_next  = 1'b1;
            step_next = '0;
            quo_next  = dividend;
            rem_next  = '0;
            div_next  = divisor;
        end
        else if (run_reg)
        begin
            quo_next  = {quo_reg[DW-2:0], fits};
            rem_next  = fits ? diff[VW-1:0] : shifted[VW-1:0];
            step_next = step_reg + 1'b1;
            if (step_reg == STEP_W'(DW - 1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        div_reg <= div_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

### rtl/drop_tail_link_queue.sv
// Drop-tail link queue top level: ring buffer, paced link and saturating statistics.
//
// Each accepted request is one microsecond tick and returns one result with the
// statistics after that tick. A tick with no send start passes S_CHECK, S_FINISH
// and S_EMIT; a tick that starts a send also passes S_START and S_DIV, where the
// 19-step serial divider turns size*8/speed into the send length. The result is
// offered once it is loaded in S_EMIT, and the next request is taken after that.
// Requests are taken one at a time; a waiting result does not hold back the next
// request until that request's own result is ready. The ring store is not cleared
// at reset; entries are only used after they are written.
module drop_tail_link_queue
#(
    parameter int QUEUE_DEPTH = 1024,
    parameter int TIME_WIDTH  = 32
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               item_valid,
    output logic                               item_stall,
    input  dtlq_pkg::item_t                    item,
    output logic                               result_valid,
    input  logic                               result_stall,
    output dtlq_pkg::result_t                  result,
    input  logic                               cfg_write,
    input  logic [dtlq_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [dtlq_pkg::CFG_W-1:0]         cfg_data
);

    localparam int IDX_W   = $clog2(QUEUE_DEPTH);
    localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
    localparam int CMP_W   = (CNT_W > dtlq_pkg::CAP_W) ? CNT_W : dtlq_pkg::CAP_W;
    localparam int FILLX_W = dtlq_pkg::FILL_W + CNT_W;
    localparam int SUM_W   = ((TIME_WIDTH > dtlq_pkg::WAIT_W) ? TIME_WIDTH
                                                              : dtlq_pkg::WAIT_W) + 1;
    localparam int SW      = dtlq_pkg::SIZE_W;
    localparam int CW      = dtlq_pkg::COUNT_W;
    localparam int WW      = dtlq_pkg::WAIT_W;
    localparam int LW      = dtlq_pkg::LIMIT_W;

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_CHECK  = 6'b000010,
        S_START  = 6'b000100,
        S_DIV    = 6'b001000,
        S_FINISH = 6'b010000,
        S_EMIT   = 6'b100000
    } state_t;

    state_t                           state_reg, state_next;
    logic [dtlq_pkg::CAP_W-1:0]       cap_reg, cap_next;
    logic [dtlq_pkg::SPEED_W-1:0]     speed_reg, speed_next;
    logic [IDX_W-1:0]                 head_reg, head_next;
    logic [IDX_W-1:0]                 tail_reg, tail_next;
    logic [CNT_W-1:0]                 fill_reg, fill_next;
    logic                             busy_reg, busy_next;
    logic [LW-1:0]                    limit_reg, limit_next;
    logic [LW-1:0]                    elapsed_reg, elapsed_next;
    logic [TIME_WIDTH-1:0]            tick_reg, tick_next;
    logic [CW-1:0]                    arr_reg, arr_next;
    logic [CW-1:0]                    del_reg, del_next;
    logic [CW-1:0]                    drp_reg, drp_next;
    logic [WW-1:0]                    wsum_reg, wsum_next;
    logic                             drop_now_reg, drop_now_next;
    logic                             done_now_reg, done_now_next;
    logic                             out_valid_reg, out_valid_next;
    dtlq_pkg::result_t                out_reg;

    logic [SW-1:0]                    size_mem [QUEUE_DEPTH];
    logic [TIME_WIDTH-1:0]            stamp_mem [QUEUE_DEPTH];
    logic [SW-1:0]                    rd_size_reg;
    logic [TIME_WIDTH-1:0]            rd_stamp_reg;
    logic                             wr_en;

    logic                             load_out;
    logic                             div_start;
    logic                             div_done;
    logic [dtlq_pkg::DIVIDEND_W-1:0]  div_quotient;
    logic [dtlq_pkg::SPEED_W-1:0]     divisor;

    logic [CMP_W-1:0]                 cap_ext;
    logic [CMP_W-1:0]                 cap_eff;
    logic [CMP_W-1:0]                 fill_ext;
    logic                             full;
    logic [TIME_WIDTH-1:0]            wait_val;
    logic [SUM_W-1:0]                 wait_add;
    logic [FILLX_W-1:0]               fill_wide;

    assign cap_ext  = CMP_W'(cap_reg);
    assign cap_eff  = (cap_ext > CMP_W'(QUEUE_DEPTH)) ? CMP_W'(QUEUE_DEPTH) : cap_ext;
    assign fill_ext = CMP_W'(fill_reg);
    assign full     = fill_ext >= cap_eff;
    assign divisor  = (speed_reg == '0) ? dtlq_pkg::SPEED_W'(1) : speed_reg;
    assign wait_val = tick_reg - rd_stamp_reg;
    assign wait_add = SUM_W'(wsum_reg) + SUM_W'(wait_val);
    assign fill_wide = FILLX_W'(fill_reg);

    dtlq_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend ({rd_size_reg, 3'b000}),
        .divisor  (divisor),
        .done     (div_done),
        .quotient (div_quotient)
    );

    always_comb
    begin
        state_next    = state_reg;
        cap_next      = cap_reg;
        speed_next    = speed_reg;
        head_next     = head_reg;
        tail_next     = tail_reg;
        fill_next     = fill_reg;
        busy_next     = busy_reg;
        limit_next    = limit_reg;
        elapsed_next  = elapsed_reg;
        tick_next     = tick_reg;
        arr_next      = arr_reg;
        del_next      = del_reg;
        drp_next      = drp_reg;
        wsum_next     = wsum_reg;
        drop_now_next = drop_now_reg;
        done_now_next = done_now_reg;
        wr_en         = 1'b0;
        div_start     = 1'b0;
        load_out      = 1'b0;

        if (cfg_write)
        begin
            case (cfg_index)
                dtlq_pkg::REG_CAPACITY: cap_next   = cfg_data[dtlq_pkg::CAP_W-1:0];
                dtlq_pkg::REG_SPEED:    speed_next = cfg_data[dtlq_pkg::SPEED_W-1:0];
                default:                ;
            endcase
        end

        case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    drop_now_next = 1'b0;
                    done_now_next = 1'b0;
                    if (item.arrival_valid)
                    begin
                        arr_next = (arr_reg == dtlq_pkg::COUNT_MAX) ? arr_reg
                                                                    : arr_reg + 1'b1;
                        if (full)
                        begin
                            drop_now_next = 1'b1;
                            drp_next = (drp_reg == dtlq_pkg::COUNT_MAX) ? drp_reg
                                                                        : drp_reg + 1'b1;
                        end
                        else
                        begin
                            wr_en     = 1'b1;
                            tail_next = (tail_reg == IDX_W'(QUEUE_DEPTH - 1)) ? '0
                                                                             : tail_reg + 1'b1;
                            fill_next = fill_reg + 1'b1;
                        end
                    end
                    state_next = S_CHECK;
                end
            end
            // head slot read issues here; data is registered for S_START
            S_CHECK:
            begin
                if (!busy_reg && fill_reg != '0)
                    state_next = S_START;
                else
                    state_next = S_FINISH;
            end
            S_START:
            begin
                wsum_next    = (wait_add > SUM_W'(dtlq_pkg::WAIT_MAX)) ? dtlq_pkg::WAIT_MAX
                                                                     : wait_add[WW-1:0];
                head_next    = (head_reg == IDX_W'(QUEUE_DEPTH - 1)) ? '0
                                                                    : head_reg + 1'b1;
                fill_next    = fill_reg - 1'b1;
                busy_next    = 1'b1;
                elapsed_next = '0;
                div_start    = 1'b1;
                state_next   = S_DIV;
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    limit_next = LW'(div_quotient);
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (busy_reg)
                begin
                    if (elapsed_reg >= limit_reg)
                    begin
                        busy_next     = 1'b0;
                        elapsed_next  = '0;
                        done_now_next = 1'b1;
                        del_next = (del_reg == dtlq_pkg::COUNT_MAX) ? del_reg
                                                                    : del_reg + 1'b1;
                    end
                    else
                    begin
                        elapsed_next = elapsed_reg + 1'b1;
                    end
                end
                tick_next  = tick_reg + 1'b1;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (!out_valid_reg || !result_stall)
                begin
                    load_out   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (load_out)
            out_valid_next = 1'b1;
        else if (!result_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cap_reg       <= dtlq_pkg::CAP_RESET;
            speed_reg     <= dtlq_pkg::SPEED_RESET;
            head_reg      <= '0;
            tail_reg      <= '0;
            fill_reg      <= '0;
            busy_reg      <= 1'b0;
            limit_reg     <= '0;
            elapsed_reg   <= '0;
            tick_reg      <= '0;
            arr_reg       <= '0;
            del_reg       <= '0;
            drp_reg       <= '0;
            wsum_reg      <= '0;
            drop_now_reg  <= 1'b0;
            done_now_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cap_reg       <= cap_next;
            speed_reg     <= speed_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            fill_reg      <= fill_next;
            busy_reg      <= busy_next;
            limit_reg     <= limit_next;
            elapsed_reg   <= elapsed_next;
            tick_reg      <= tick_next;
            arr_reg       <= arr_next;
            del_reg       <= del_next;
            drp_reg       <= drp_next;
            wsum_reg      <= wsum_next;
            drop_now_reg  <= drop_now_next;
            done_now_reg  <= done_now_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // ring store: write at tail on admission, head read registered every cycle
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            size_mem[tail_reg]  <= item.packet_size;
            stamp_mem[tail_reg] <= tick_reg;
        end
        rd_size_reg  <= size_mem[head_reg];
        rd_stamp_reg <= stamp_mem[head_reg];
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_reg.dropped_now     <= drop_now_reg;
            out_reg.delivered_now   <= done_now_reg;
            out_reg.arrived_total   <= arr_reg;
            out_reg.delivered_total <= del_reg;
            out_reg.dropped_total   <= drp_reg;
            out_reg.wait_sum        <= wsum_reg;
            out_reg.queue_fill      <= fill_wide[dtlq_pkg::FILL_W-1:0];
            out_reg.link_busy       <= busy_reg;
        end
    end

    assign item_stall   = (state_reg != S_IDLE);
    assign result_valid = out_valid_reg;
    assign result       = out_reg;

endmodule

### rtl/dtlq_checker.sv
// Port-level checks for the drop-tail link queue, bound to the top level.
module dtlq_checker
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    input  logic              item_stall,
    input  logic              result_valid,
    input  logic              result_stall,
    input  dtlq_pkg::result_t result
);

    // a result that is held back stays offered
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid)
        else $error("result withdrawn while stalled");

    // one request at a time: the cycle after acceptance is always stalled
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && !item_stall |=> item_stall)
        else $error("request accepted back to back");

    a_drop_counted: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.dropped_now |-> result.dropped_total != 32'd0)
        else $error("drop flagged with zero drop count");

    // a completed send leaves the link idle for that tick
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.delivered_now |->
            !result.link_busy && result.delivered_total != 32'd0)
        else $error("delivery flagged with busy link or zero count");

endmodule

bind drop_tail_link_queue dtlq_checker u_dtlq_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
);
